// ===== rtl/hoct_pkg.sv =====
// hoct_pkg: shared types and constants of the hot offset counter table
// depends on nothing; imported by hoct_cam and hot_offset_counter_table
package hoct_pkg;

	localparam int KEY_W   = 32;
	localparam int COUNT_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(1000);

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic {
		CMD_OBSERVE = 1'b0,
		CMD_QUERY   = 1'b1
	} cmd_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

endpackage

// ===== rtl/hoct_cam.sv =====
// hoct_cam: key store of the offset table with a parallel match over the used entries
// depends on hoct_pkg for the key type
module hoct_cam #(
	parameter int ENTRIES = 64,
	parameter int IDX_W   = 6,
	parameter int CNT_W   = 7
) (
	input  logic                 clk,
	input  logic                 key_we,
	input  logic [IDX_W-1:0]     key_widx,
	input  hoct_pkg::key_t       key_wdata,
	input  logic [CNT_W-1:0]     used,
	input  hoct_pkg::key_t       lookup_key,
	output logic                 hit,
	output logic [IDX_W-1:0]     hit_idx
);
	import hoct_pkg::*;

	key_t             keys_q [ENTRIES];
	logic [ENTRIES-1:0] match;

	always_ff @(posedge clk) begin
		if (key_we) begin
			keys_q[key_widx] <= key_wdata;
		end
	end

	// keys are unique, so at most one entry matches and the index is an or of candidates
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (CNT_W'(i) < used) && (keys_q[i] == lookup_key);
			hit_idx  = hit_idx | (IDX_W'(i) & {IDX_W{match[i]}});
		end
		hit = |match;
	end

endmodule

// ===== rtl/hot_offset_counter_table.sv =====
// hot_offset_counter_table: execution profiler mapping code offsets to saturating counts
// depends on hoct_pkg and hoct_cam
//
// usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one item: an offset and a command
//   (observe one execution, or query the offset's profile). every item gives
//   exactly one result on m_tvalid/m_tready/m_tdata.
//   cfg_we/cfg_wdata write the hot threshold; write only while the block is idle.
// timing:
//   an item is matched against the used keys in the accept cycle, which also reads the
//   count memory; the item then waits in the match stage until the output register
//   is free, and that cycle updates the count and loads the output register.
//   one item is in the match stage at a time, so the block takes no new item until
//   the current one has left the match stage.
// reset:
//   the table is empty and the threshold is 1000. the key and count stores are
//   not cleared; an entry count tracks which entries are in use.
// stall:
//   while m_tready is low the result holds; one more item may be accepted and
//   waits in the match stage until the output register frees.
module hot_offset_counter_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  hoct_pkg::count_t     cfg_wdata,   // hot limit
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  hoct_pkg::key_t       s_tdata,     // code_offset[31:0]
	input  logic                 s_tuser,     // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata      // hot_now, found, exec_count, is_hot, status, pad
);
	import hoct_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	count_t             thr_q;
	logic [CNT_W-1:0]   used_q;
	logic               valid_s1;
	cmd_t               cmd_s1;
	key_t               key_s1;
	logic               hit_s1;
	logic [IDX_W-1:0]   idx_s1;
	count_t             cnt_rd_s1;
	logic               out_valid_q;
	logic [39:0]        out_data_q;

	count_t             count_mem [TABLE_ENTRIES];

	logic               accept;
	logic               adv;
	logic               cam_hit;
	logic [IDX_W-1:0]   cam_idx;
	logic               full;
	logic               is_obs;
	logic               alloc;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	count_t             cur;
	count_t             upd;
	logic               r_hot_now;
	logic               r_found;
	count_t             r_count;
	logic               r_is_hot;
	status_t            r_status;

	assign s_tready = !valid_s1;
	assign accept   = s_tvalid && s_tready;
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	hoct_cam #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W),
		.CNT_W   (CNT_W)
	) u_cam (
		.clk        (clk),
		.key_we     (adv && alloc),
		.key_widx   (used_q[IDX_W-1:0]),
		.key_wdata  (key_s1),
		.used       (used_q),
		.lookup_key (s_tdata),
		.hit        (cam_hit),
		.hit_idx    (cam_idx)
	);

	always_comb begin
		full   = (used_q == CNT_W'(TABLE_ENTRIES));
		is_obs = (cmd_s1 == CMD_OBSERVE);
		alloc  = is_obs && !hit_s1 && !full;
		wr_en  = adv && is_obs && (hit_s1 || !full);
		wr_idx = hit_s1 ? idx_s1 : used_q[IDX_W-1:0];
		cur    = hit_s1 ? cnt_rd_s1 : '0;
		upd    = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);

		r_hot_now = 1'b0;
		r_found   = 1'b0;
		r_count   = '0;
		r_is_hot  = 1'b0;
		r_status  = STATUS_OK;
		unique case (cmd_s1)
			CMD_OBSERVE: begin
				if (hit_s1 || !full) begin
					r_hot_now = (cur != COUNT_MAX) && (upd == thr_q);
					r_count   = upd;
					r_is_hot  = (upd >= thr_q);
				end else begin
					r_status = STATUS_FULL;
				end
			end
			CMD_QUERY: begin
				if (hit_s1) begin
					r_found  = 1'b1;
					r_count  = cnt_rd_s1;
					r_is_hot = (cnt_rd_s1 >= thr_q);
				end
			end
			default: begin
				r_status = STATUS_OK;
			end
		endcase
	end

	// count memory: read at accept, written back when an observe that holds an entry leaves the match stage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			count_mem[wr_idx] <= upd;
		end
		if (accept) begin
			cnt_rd_s1 <= count_mem[cam_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(s_tuser);
			key_s1 <= s_tdata;
			hit_s1 <= cam_hit;
			idx_s1 <= cam_idx;
		end
		if (adv) begin
			out_data_q <= {4'b0, r_status, r_is_hot, r_count, r_found, r_hot_now};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESHOLD_RESET;
			used_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (adv && alloc) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[35]) |-> (used_q == CNT_W'(TABLE_ENTRIES)))
		else $error("table full reported while entries remain");

	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && alloc) |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("allocation did not advance entry count");

	a_hot_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[34] && !m_tdata[1] && m_tdata[33:2] == thr_q))
		else $error("hot_now without matching count");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (valid_s1 && !s_tready))
		else $error("second item admitted into match stage");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for hot_offset_counter_table, observe and query items
// over the stream ports, checked against a table predictor inside the bench
// depends on hoct_pkg and the hot_offset_counter_table rtl
module tb_top;
	import hoct_pkg::*;

	localparam int DEPTH       = 64;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 244;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic    hot_now;
		logic    found;
		count_t  exec_count;
		logic    is_hot;
		status_t status;
	} profile_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cmd_t      cmd;
		key_t      key;     // threshold value on a register row
		bit        typed;
		profile_t  want;
	} row_t;

	localparam profile_t NO_PROFILE = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	count_t      cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	key_t        s_tdata = '0;
	logic        s_tuser = CMD_OBSERVE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	key_t       offset_tab [DEPTH];
	count_t     count_tab [DEPTH];
	int         offsets_used = 0;
	count_t     hot_level = THRESHOLD_RESET;
	profile_t   pending_profiles [$];
	key_t       known_offsets [$];
	int         mismatches = 0;
	int         stall_cycles = 0;
	bit         idle_on = 1'b1;

	row_t directed [23] = '{
		'{ROW_ITEM, CMD_QUERY,   32'h0,        1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'h0,        1'b1, '{1'b0, 1'b0, 32'd1, 1'b0, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'd1, 1'b0, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'h0,        1'b1, '{1'b0, 1'b0, 32'd2, 1'b0, STATUS_OK}},
		'{ROW_ITEM, CMD_QUERY,   32'h0,        1'b1, '{1'b0, 1'b1, 32'd2, 1'b0, STATUS_OK}},
		'{ROW_ITEM, CMD_QUERY,   32'h12345678, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, STATUS_OK}},
		'{ROW_CFG,  CMD_OBSERVE, 32'd2,        1'b0, NO_PROFILE},
		'{ROW_ITEM, CMD_OBSERVE, 32'hFFFFFFFF, 1'b1, '{1'b1, 1'b0, 32'd2, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'd3, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_QUERY,   32'hFFFFFFFF, 1'b1, '{1'b0, 1'b1, 32'd3, 1'b1, STATUS_OK}},
		'{ROW_CFG,  CMD_OBSERVE, 32'd0,        1'b0, NO_PROFILE},
		'{ROW_ITEM, CMD_QUERY,   32'h0,        1'b1, '{1'b0, 1'b1, 32'd2, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'hAAAAAAAA, 1'b1, '{1'b0, 1'b0, 32'd1, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_QUERY,   32'hAAAAAAAA, 1'b0, NO_PROFILE},
		'{ROW_CFG,  CMD_OBSERVE, 32'hFFFFFFFF, 1'b0, NO_PROFILE},
		'{ROW_ITEM, CMD_OBSERVE, 32'h55555555, 1'b1, '{1'b0, 1'b0, 32'd1, 1'b0, STATUS_OK}},
		'{ROW_ITEM, CMD_QUERY,   32'hAAAAAAAA, 1'b1, '{1'b0, 1'b1, 32'd1, 1'b0, STATUS_OK}},
		'{ROW_CFG,  CMD_OBSERVE, 32'd1,        1'b0, NO_PROFILE},
		'{ROW_ITEM, CMD_OBSERVE, 32'h80000000, 1'b1, '{1'b1, 1'b0, 32'd1, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'h00000001, 1'b1, '{1'b1, 1'b0, 32'd1, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_OBSERVE, 32'h0,        1'b1, '{1'b0, 1'b0, 32'd3, 1'b1, STATUS_OK}},
		'{ROW_ITEM, CMD_QUERY,   32'h7FFFFFFF, 1'b0, NO_PROFILE},
		'{ROW_ITEM, CMD_OBSERVE, 32'h7FFFFFFF, 1'b0, NO_PROFILE}
	};

	hot_offset_counter_table #(.TABLE_ENTRIES(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // code_offset[31:0]
		.s_tuser   (s_tuser),     // cmd
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)      // hot_now, found, exec_count[31:0], is_hot, status, pad
	);

	always #5 clk = ~clk;

	function automatic profile_t profile_step(cmd_t cmd, key_t key);
		profile_t p;
		int slot;
		p = '0;
		slot = -1;
		for (int i = 0; i < offsets_used; i++) begin
			if (slot < 0 && offset_tab[i] == key)
				slot = i;
		end
		if (cmd == CMD_OBSERVE) begin
			if (slot < 0) begin
				if (offsets_used >= DEPTH) begin
					p.status = STATUS_FULL;
				end else begin
					slot = offsets_used;
					offset_tab[slot] = key;
					count_tab[slot] = '0;
					offsets_used++;
				end
			end
			if (slot >= 0) begin
				if (count_tab[slot] != COUNT_MAX) begin
					count_tab[slot] = count_tab[slot] + 1'b1;
					p.hot_now = (count_tab[slot] == hot_level);
				end
				p.exec_count = count_tab[slot];
				p.is_hot = (count_tab[slot] >= hot_level);
			end
		end else if (slot >= 0) begin
			p.found = 1'b1;
			p.exec_count = count_tab[slot];
			p.is_hot = (count_tab[slot] >= hot_level);
		end
		return p;
	endfunction

	task automatic send_item(input cmd_t cmd, input key_t key, input bit typed,
			input profile_t want);
		profile_t p;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 33) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = key;
		do @(posedge clk); while (!s_tready);
		p = profile_step(cmd, key);
		pending_profiles.push_back(typed ? want : p);
	endtask

	task automatic set_threshold(input count_t value);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_profiles.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		hot_level = value;
	endtask

	always @(negedge clk) begin
		m_tready = !idle_on || ($urandom_range(99) >= 33);
	end

	always @(posedge clk) begin
		profile_t want;
		if (m_tvalid && m_tready) begin
			if (pending_profiles.size() == 0) begin
				$error("result with no item pending: %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_profiles.pop_front();
				if (m_tdata[0] !== want.hot_now) begin
					$error("hot_now: expected %0d, got %0d", want.hot_now, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[1] !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, m_tdata[1]);
					mismatches++;
				end
				if (m_tdata[33:2] !== want.exec_count) begin
					$error("exec_count: expected %0h, got %0h", want.exec_count,
						m_tdata[33:2]);
					mismatches++;
				end
				if (m_tdata[34] !== want.is_hot) begin
					$error("is_hot: expected %0d, got %0d", want.is_hot, m_tdata[34]);
					mismatches++;
				end
				if (m_tdata[35] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[35]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		count_t th_plan [PHASES];
		key_t edge_keys [4];
		count_t th;
		cmd_t cmd;
		key_t key;
		int r;
		th_plan = '{32'd3, 32'd0, 32'd8, 32'd1, 32'd16, 32'hFFFFFFFF, 32'd0, 32'd24};
		edge_keys = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h00000001};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				set_threshold(directed[i].key);
			end else begin
				send_item(directed[i].cmd, directed[i].key, directed[i].typed,
					directed[i].want);
				if (directed[i].cmd == CMD_OBSERVE)
					known_offsets.push_back(directed[i].key);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			th = (p == 6) ? count_t'($urandom_range(2, 40)) : th_plan[p];
			set_threshold(th);
			idle_on = (p != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < 12) begin
					// fresh offset, fills the table and later hits the full case
					cmd = CMD_OBSERVE;
					key = $urandom;
					if (known_offsets.size() < 90)
						known_offsets.push_back(key);
				end else if (r < 17) begin
					cmd = CMD_QUERY;
					key = $urandom;
				end else if (r < 20) begin
					cmd = cmd_t'($urandom_range(1));
					key = edge_keys[$urandom_range(3)];
				end else begin
					cmd = (r < 70) ? CMD_OBSERVE : CMD_QUERY;
					key = known_offsets[$urandom_range(known_offsets.size() - 1)];
				end
				send_item(cmd, key, 1'b0, NO_PROFILE);
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		idle_on = 1'b1;
		while (pending_profiles.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_profiles.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
